### rtl/selu_pkg.sv
`timescale 1ns / 1ps

package selu_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LAMBDA = 2'd0,
    CFG_ALPHA  = 2'd1
  } selu_cfg_e;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SCALE_W   = 18;
  localparam int unsigned SCALE_FRAC = 16;
  localparam int unsigned AL_W      = 2 * SCALE_W;

  localparam logic [SCALE_W-1:0] LAMBDA_RST = 18'd68859;
  localparam logic [SCALE_W-1:0] ALPHA_RST  = 18'd109659;

  // Exponential datapath constants, all Q1.30 based.
  localparam int unsigned      NTERMS   = 9;
  localparam logic [29:0]      LN2_Q30  = 30'd744261118;
  localparam logic [30:0]      Q30_ONE  = 31'h4000_0000;
  // 31 * ln2 in Q.30: at or above this the exponential is zero.
  localparam logic [34:0]      SAT_LIM  = 35'd23072094658;

  // Stage counts of the submodules.
  localparam int unsigned RR_LAT    = 6;
  localparam int unsigned HSTEP_LAT = 3;
  localparam int unsigned POST_LAT  = 4;
  localparam int unsigned PIPE_LAT  = 1 + RR_LAT + NTERMS * HSTEP_LAT + POST_LAT;

  // What travels down the series chain next to the running product.
  typedef struct packed {
    logic [29:0] r;
    logic [4:0]  k;
    logic        sat;
  } selu_lane_t;

endpackage

### rtl/selu_rr.sv
`timescale 1ns / 1ps

// Range reduction of a negative sample, |x| = k*ln2 + r: one k bit per divide stage.
module selu_rr #(
  parameter int unsigned DATA_WIDTH = 24,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [DATA_WIDTH-1:0] sample_i,
  output logic                  valid_o,
  output selu_pkg::selu_lane_t  lane_o
);

  localparam int unsigned SH = 30 - FRAC_BITS;
  localparam int unsigned TW = DATA_WIDTH + SH;
  localparam int unsigned RW = (TW > 35) ? TW : 35;
  localparam int unsigned NS = selu_pkg::RR_LAT;

  logic [DATA_WIDTH-1:0] mag;
  logic [RW-1:0]         t30;
  logic                  sat;

  logic [34:0] rem_q [NS];
  logic [4:0]  k_q   [NS];
  logic        sat_q [NS];
  logic        v_q   [NS];

  assign mag = '0 - sample_i;
  assign t30 = RW'(mag) << SH;
  assign sat = t30 >= RW'(selu_pkg::SAT_LIM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= t30[34:0];
    k_q[0]   <= '0;
    sat_q[0] <= sat;
  end

  for (genvar s = 1; s < NS; s++) begin : g_div
    localparam int unsigned J = NS - 1 - s;
    localparam logic [34:0] STEP = 35'(selu_pkg::LN2_Q30) << J;
    logic take;

    assign take = rem_q[s-1] >= STEP;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= take ? (rem_q[s-1] - STEP) : rem_q[s-1];
      k_q[s]   <= k_q[s-1] | (take ? (5'd1 << J) : 5'd0);
      sat_q[s] <= sat_q[s-1];
    end
  end

  assign valid_o    = v_q[NS-1];
  assign lane_o.r   = rem_q[NS-1][29:0];
  assign lane_o.k   = k_q[NS-1];
  assign lane_o.sat = sat_q[NS-1];

endmodule

### rtl/selu_hstep.sv
`timescale 1ns / 1ps

// One Horner term of the exp(-r) series: p_o = 1 - ((r * p_i) >> 30) / N.
// Stage 1 multiplies, stage 2 shifts or reciprocal-divides by N, stage 3 corrects.
module selu_hstep #(
  parameter int unsigned N = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [30:0]          p_i,
  input  selu_pkg::selu_lane_t lane_i,
  output logic                 valid_o,
  output logic [30:0]          p_o,
  output selu_pkg::selu_lane_t lane_o
);

  localparam bit          POW2  = (N & (N - 1)) == 0;
  localparam int unsigned LOG2N = $clog2(N);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / N);
  localparam logic [29:0] NC    = 30'(N);

  logic [60:0] prod;
  logic [29:0] est;
  logic [29:0] rem;
  logic [29:0] quo;

  logic [29:0]          q1_q;
  selu_pkg::selu_lane_t lane1_q;
  logic [29:0]          q2_q;
  logic [29:0]          est2_q;
  selu_pkg::selu_lane_t lane2_q;
  logic [30:0]          p3_q;
  selu_pkg::selu_lane_t lane3_q;
  logic                 v1_q, v2_q, v3_q;

  assign prod = 61'(lane_i.r) * 61'(p_i);

  if (POW2) begin : g_shift
    assign est = q1_q >> LOG2N;
  end else begin : g_recip
    logic [61:0] qm;
    assign qm  = 62'(q1_q) * 62'(RECIP);
    assign est = qm[61:32];
  end

  // The reciprocal estimate is at most one below the true quotient.
  assign rem = q2_q - (est2_q * NC);
  assign quo = (rem >= NC) ? (est2_q + 30'd1) : est2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q    <= prod[59:30];
    lane1_q <= lane_i;
    q2_q    <= q1_q;
    est2_q  <= est;
    lane2_q <= lane1_q;
    p3_q    <= selu_pkg::Q30_ONE - 31'(quo);
    lane3_q <= lane2_q;
  end

  assign valid_o = v3_q;
  assign p_o     = p3_q;
  assign lane_o  = lane3_q;

endmodule

### rtl/selu_post.sv
`timescale 1ns / 1ps

// Turns exp(x) into alpha*lambda*(exp(x)-1), clamps, and picks the branch.
module selu_post #(
  parameter int unsigned DATA_WIDTH = 24,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [30:0]                   p_i,
  input  selu_pkg::selu_lane_t          lane_i,
  input  logic [selu_pkg::AL_W-1:0]     al_i,
  input  logic                          neg_i,
  input  logic [DATA_WIDTH-1:0]         pos_res_i,
  input  logic                          pos_clamp_i,
  output logic                          valid_o,
  output logic [DATA_WIDTH-1:0]         res_o,
  output logic                          clamp_o
);

  localparam int unsigned ESH = 30 - FRAC_BITS;
  localparam int unsigned DW1 = FRAC_BITS + 1;
  localparam int unsigned HW  = selu_pkg::SCALE_W;
  localparam int unsigned PLW = DW1 + HW;
  localparam int unsigned SW  = FRAC_BITS + selu_pkg::AL_W + 2;
  localparam int unsigned MW  = SW - 32;
  localparam int unsigned CW  = ((MW > DATA_WIDTH) ? MW : DATA_WIDTH) + 1;

  localparam logic [31:0]     EHALF = 32'd1 << (ESH - 1);
  localparam logic [DW1-1:0]  ONE   = DW1'(1) << FRAC_BITS;
  localparam logic [SW-1:0]   RND   = SW'(1) << 31;
  localparam logic [CW-1:0]   NLIM  = CW'(1) << (DATA_WIDTH - 1);

  logic [30:0]           e30;
  logic [31:0]           erd;
  logic [DW1-1:0]        e;
  logic [SW-1:0]         sum;
  logic [MW-1:0]         mag;
  logic                  nclamp;
  logic [DATA_WIDTH-1:0] nmag;
  logic [DATA_WIDTH-1:0] nres;

  logic [DW1-1:0]        d1_q, d2_q;
  logic [PLW-1:0]        pl2_q, pl3_q;
  logic [PLW-1:0]        ph3_q;
  logic [DATA_WIDTH-1:0] res_q;
  logic                  clamp_q;
  logic                  v1_q, v2_q, v3_q, v4_q;

  // exp(x) with FRAC_BITS fraction bits, rounded half up.
  assign e30 = lane_i.sat ? 31'd0 : (p_i >> lane_i.k);
  assign erd = (32'(e30) + EHALF) >> ESH;
  assign e   = erd[DW1-1:0];

  assign sum    = (SW'(ph3_q) << HW) + SW'(pl3_q) + RND;
  assign mag    = sum[SW-1:32];
  assign nclamp = CW'(mag) > NLIM;
  assign nmag   = nclamp ? DATA_WIDTH'(NLIM) : DATA_WIDTH'(mag);
  assign nres   = '0 - nmag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q    <= (e >= ONE) ? '0 : (ONE - e);
    d2_q    <= d1_q;
    pl2_q   <= PLW'(d1_q) * PLW'(al_i[HW-1:0]);
    pl3_q   <= pl2_q;
    ph3_q   <= PLW'(d2_q) * PLW'(al_i[selu_pkg::AL_W-1:HW]);
    res_q   <= neg_i ? nres : pos_res_i;
    clamp_q <= neg_i ? nclamp : pos_clamp_i;
  end

  assign valid_o = v4_q;
  assign res_o   = res_q;
  assign clamp_o = clamp_q;

endmodule

### rtl/selu_activation_unit_core.sv
`timescale 1ns / 1ps

// SELU activation unit.
// An item is one signed fixed-point sample (FRAC_BITS fraction bits) presented on
// sample_in_i and taken at a rising edge where start_i is high and busy_o is low.
// The result appears on sample_out_o and clamped_o for exactly one cycle, marked
// by done_o. The pipeline takes a new item every cycle, so throughput is one item
// per clock. An item passes through the entry register, six range-reduction
// stages, the nine series terms of the exponential, each three stages deep
// (product, reciprocal multiply or shift, quotient correction), and four output
// stages. The receiver cannot hold results off, so nothing ever backs up inside.
// Reset empties the pipeline and loads the default lambda and alpha; busy_o is
// high during reset and for the first cycle after it, and low from then on.
// lambda (register 0) and alpha (register 1) are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; other indexes are ignored. The user must write
// them only while no item is in flight; the block itself does not enforce this.
module selu_activation_unit_core #(
  parameter int unsigned DATA_WIDTH = 24,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [DATA_WIDTH-1:0]        sample_in_i,
  input  logic                                cfg_we_i,
  input  logic [selu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [selu_pkg::SCALE_W-1:0]        cfg_wdata_i,
  output logic                                done_o,
  output logic signed [DATA_WIDTH-1:0]        sample_out_o,
  output logic                                clamped_o
);

  localparam int unsigned SW   = selu_pkg::SCALE_W;
  localparam int unsigned PPW  = DATA_WIDTH + SW;
  localparam int unsigned PMW  = PPW + 1 - selu_pkg::SCALE_FRAC;
  localparam int unsigned NT   = selu_pkg::NTERMS;
  // Stages between the positive-branch result and the final output stage.
  localparam int unsigned DLY  = selu_pkg::RR_LAT + NT * selu_pkg::HSTEP_LAT
                                 + selu_pkg::POST_LAT - 3;
  localparam int unsigned SIDW = DATA_WIDTH + 2;

  localparam logic [PPW:0]   PRND = (PPW + 1)'(1) << (selu_pkg::SCALE_FRAC - 1);
  localparam logic [PMW-1:0] PMAX = (PMW'(1) << (DATA_WIDTH - 1)) - PMW'(1);

  // Config registers and product; user changes them only while idle, unenforced.
  logic [SW-1:0]                lambda_q;
  logic [SW-1:0]                alpha_q;
  logic [selu_pkg::AL_W-1:0]    al_q;
  logic                         busy_q;

  // Entry register.
  logic [DATA_WIDTH-1:0]        in_q;
  logic                         in_v_q;
  logic                         accept;

  // Positive branch: lambda * x, rounded and clamped, then delayed to the output.
  logic [PPW-1:0]               pprod_q;
  logic                         neg2_q, neg3_q;
  logic [PPW:0]                 psum;
  logic [PMW-1:0]               pmag;
  logic                         pclamp;
  logic [DATA_WIDTH-1:0]        pres_q;
  logic                         pclamp_q;
  logic [SIDW-1:0]              side_q [DLY];
  logic [SIDW-1:0]              side_out;

  // Negative branch.
  logic                         rr_v;
  selu_pkg::selu_lane_t         rr_lane;
  logic                         hs_v    [NT+1];
  logic [30:0]                  hs_p    [NT+1];
  selu_pkg::selu_lane_t         hs_lane [NT+1];

  logic                         post_v;
  logic [DATA_WIDTH-1:0]        post_res;
  logic                         post_clamp;

  assign accept = start_i && !busy_q;
  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= selu_pkg::LAMBDA_RST;
      alpha_q  <= selu_pkg::ALPHA_RST;
      busy_q   <= 1'b1;
      in_v_q   <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      in_v_q <= accept;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          selu_pkg::CFG_LAMBDA: lambda_q <= cfg_wdata_i;
          selu_pkg::CFG_ALPHA:  alpha_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    al_q <= selu_pkg::AL_W'(alpha_q) * selu_pkg::AL_W'(lambda_q);
    if (accept) begin
      in_q <= sample_in_i;
    end
  end

  // The positive path runs on every item; the sign picks the branch at the end.
  assign psum   = (PPW + 1)'(pprod_q) + PRND;
  assign pmag   = psum[PPW:selu_pkg::SCALE_FRAC];
  assign pclamp = pmag > PMAX;

  always_ff @(posedge clk_i) begin
    pprod_q  <= PPW'(in_q) * PPW'(lambda_q);
    neg2_q   <= in_q[DATA_WIDTH-1];
    neg3_q   <= neg2_q;
    pres_q   <= pclamp ? DATA_WIDTH'(PMAX) : pmag[DATA_WIDTH-1:0];
    pclamp_q <= pclamp;
    side_q[0] <= {neg3_q, pclamp_q, pres_q};
  end

  for (genvar i = 1; i < DLY; i++) begin : g_side
    always_ff @(posedge clk_i) begin
      side_q[i] <= side_q[i-1];
    end
  end

  assign side_out = side_q[DLY-1];

  selu_rr #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_rr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_v_q),
    .sample_i (in_q),
    .valid_o  (rr_v),
    .lane_o   (rr_lane)
  );

  assign hs_v[0]    = rr_v;
  assign hs_p[0]    = selu_pkg::Q30_ONE;
  assign hs_lane[0] = rr_lane;

  // Horner chain over the series terms, divisor nine down to one.
  for (genvar i = 0; i < NT; i++) begin : g_term
    selu_hstep #(
      .N (NT - i)
    ) u_hstep (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (hs_v[i]),
      .p_i     (hs_p[i]),
      .lane_i  (hs_lane[i]),
      .valid_o (hs_v[i+1]),
      .p_o     (hs_p[i+1]),
      .lane_o  (hs_lane[i+1])
    );
  end

  selu_post #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (hs_v[NT]),
    .p_i         (hs_p[NT]),
    .lane_i      (hs_lane[NT]),
    .al_i        (al_q),
    .neg_i       (side_out[SIDW-1]),
    .pos_res_i   (side_out[DATA_WIDTH-1:0]),
    .pos_clamp_i (side_out[DATA_WIDTH]),
    .valid_o     (post_v),
    .res_o       (post_res),
    .clamp_o     (post_clamp)
  );

  assign done_o       = post_v;
  assign sample_out_o = post_res;
  assign clamped_o    = post_clamp;

endmodule

### rtl/selu_checker.sv
`timescale 1ns / 1ps

module selu_checker #(
  parameter int unsigned DATA_WIDTH = 24
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic signed [DATA_WIDTH-1:0]   sample_in_i,
  input logic                           done_o,
  input logic signed [DATA_WIDTH-1:0]   sample_out_o,
  input logic                           clamped_o
);

  localparam int unsigned LAT = selu_pkg::PIPE_LAT;
  localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  // Every accepted item produces a result on done_o.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("accepted item produced no result");

  // No result appears on done_o without a matching accepted item.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without a matching item");

  // A clamped result sits on one of the range limits.
  a_clamp_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && clamped_o) |-> (sample_out_o == MAXV || sample_out_o == MINV))
    else $error("clamped result is not a range limit");

  // A non-negative sample never gives a negative result.
  a_pos_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !sample_in_i[DATA_WIDTH-1]) |-> ##LAT !sample_out_o[DATA_WIDTH-1])
    else $error("non-negative sample gave a negative result");

endmodule

bind selu_activation_unit_core selu_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_selu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .sample_in_i  (sample_in_i),
  .done_o       (done_o),
  .sample_out_o (sample_out_o),
  .clamped_o    (clamped_o)
);
